// ----- rtl/neighbour_mean_filter_3x3_top_assert.svh -----
// assertion macros for the checker file of the 3x3 neighbour mean filter
// depends on: signals named clk and rst in the scope that uses the macros
`ifndef NEIGHBOUR_MEAN_FILTER_3X3_TOP_ASSERT_SVH
`define NEIGHBOUR_MEAN_FILTER_3X3_TOP_ASSERT_SVH

// same-cycle implication, off while in reset
`define NMF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");

// next-cycle implication, off while in reset
`define NMF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");

// next-cycle implication that also runs through reset
`define NMF_ASSERT_NEXT_ALWAYS(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

// ----- rtl/nmf3x3_pkg.sv -----
// shared types and constants of the 3x3 neighbour mean filter
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package nmf3x3_pkg;

  localparam int PIX_W        = 24;
  localparam int OUT_W        = 32;
  localparam int CH_W         = 8;
  localparam int SUM_W        = 11;
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 13;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_IDX_W    = 1;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd480;
  localparam logic [CH_W-1:0]         ALPHA        = 8'hFF;

  // reciprocals for the constant dividers
  localparam logic [9:0]  RECIP3 = 10'd683;   // /3 as *683 >> 11
  localparam logic [10:0] RECIP5 = 11'd1639;  // /5 as *1639 >> 13

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef enum logic [0:0] {
    CMD_PIXEL = 1'b0,
    CMD_DRAIN = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    DIV_BY_3,
    DIV_BY_5,
    DIV_BY_8
  } div_sel_t;

  // which window rows and columns lie inside the image
  typedef struct packed {
    logic top_ok;
    logic bot_ok;
    logic left_ok;
    logic right_ok;
  } win_mask_t;

endpackage

`default_nettype wire

// ----- rtl/nmf3x3_if.sv -----
// valid/ready stream interfaces for the pixel input and the result output
// depends on: nmf3x3_pkg
`timescale 1ns / 1ps
`default_nettype none

interface nmf3x3_in_if import nmf3x3_pkg::*;;
  logic             valid;
  logic             ready;
  logic             cmd;
  logic [PIX_W-1:0] pixel_in;

  modport source (output valid, output cmd, output pixel_in, input ready);
  modport sink   (input valid, input cmd, input pixel_in, output ready);
endinterface

interface nmf3x3_out_if import nmf3x3_pkg::*;;
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] pixel_out;
  logic             frame_last;

  modport source (output valid, output pixel_out, output frame_last, input ready);
  modport sink   (input valid, input pixel_out, input frame_last, output ready);
endinterface

`default_nettype wire

// ----- rtl/nmf3x3_ram.sv -----
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module nmf3x3_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/neighbour_mean_filter_3x3_top.sv -----
// 3x3 neighbour mean filter. Pixels come in raster order, one beat per clock while din.ready is high, and
// each result is the per-channel mean of the in-image neighbours of a pixel (3, 5
// or 8 of them, truncated), with channels 0 and 2 swapped and alpha 0xFF. The
// result for raster position n is computed from input beat n+width+1 and is valid on
// dout once that beat has passed the stage 1, stage 2 and output registers; after a frame,
// width+1 beats of any kind flush the last row.
// Sustained rate is one beat per clock while dout.ready holds: each line store is read
// once at accept and written when a pixel beat leaves stage 1. The line stores need no
// clearing after reset. Writing image_width or image_height restarts the frame.
// depends on: nmf3x3_pkg, nmf3x3_if, nmf3x3_ram
`timescale 1ns / 1ps
`default_nettype none

module neighbour_mean_filter_3x3_top import nmf3x3_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  nmf3x3_in_if.sink             din,
  nmf3x3_out_if.source          dout
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int HW = $clog2(MAX_HEIGHT + 1);

  // configuration
  logic [WIDTH_REG_W-1:0]  image_width;
  logic [HEIGHT_REG_W-1:0] image_height;
  logic [CW-1:0]           w_used;
  logic [HW-1:0]           h_used;

  // position state
  logic [AW-1:0] col;
  logic [RW-1:0] row;
  logic          draining;
  logic [CW-1:0] drain_cnt;

  // stage 1: line store data arriving
  logic             s1_valid;
  logic             s1_is_pixel;
  logic             s1_use_store;
  logic             s1_emit;
  logic             s1_last;
  logic [AW-1:0]    s1_addr;
  logic [PIX_W-1:0] s1_pix;
  win_mask_t        s1_mask;

  // stage 2: channel sums
  logic             s2_valid;
  logic [SUM_W-1:0] s2_sum [3];
  div_sel_t         s2_div;
  logic             s2_last;

  // stage 3: output register
  logic             s3_valid;
  logic [OUT_W-1:0] s3_pixel;
  logic             s3_last;

  logic accept, enters, s1_move, s2_move, s2_free, s3_free;

  logic [PIX_W-1:0] up_rd, mid_rd;
  logic [PIX_W-1:0] win [9];
  logic [PIX_W-1:0] win_next [9];
  logic [PIX_W-1:0] top_v, mid_v, bot_v;
  logic [8:0]       cell_ok;
  logic [SUM_W-1:0] sum_next [3];
  div_sel_t         div_next;
  logic [2:0]       n_out;

  logic [AW-1:0]    jj;
  logic [RW-1:0]    ii;
  logic [AW-1:0]    raddr;
  logic             use_store_in;
  logic             emit_in;
  logic             last_in;
  win_mask_t        mask_in;

  logic [CH_W-1:0]  mean [3];
  logic [20:0]      p3 [3];
  logic [23:0]      p5 [3];

  // clamp registers to their legal range
  always_comb begin
    if (32'(image_width) < 32'd2) begin
      w_used = CW'(2);
    end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
      w_used = CW'(MAX_WIDTH);
    end else begin
      w_used = CW'(image_width);
    end
    if (32'(image_height) < 32'd2) begin
      h_used = HW'(2);
    end else if (32'(image_height) > 32'(MAX_HEIGHT)) begin
      h_used = HW'(MAX_HEIGHT);
    end else begin
      h_used = HW'(image_height);
    end
  end

  // handshake and stage movement
  assign s3_free   = !s3_valid || dout.ready;
  assign s2_move   = s2_valid && s3_free;
  assign s2_free   = !s2_valid || s3_free;
  assign s1_move   = s1_valid && (!s1_emit || s2_free);
  assign din.ready = !s1_valid || s1_move;
  assign accept    = din.valid && din.ready;
  // drain beats outside a flush leave no trace
  assign enters    = draining || (din.cmd == CMD_PIXEL);

  // position of the incoming beat and the window it completes
  always_comb begin
    jj = (CW'(col) >= w_used) ? '0 : col;
    ii = (HW'(row) >= h_used) ? '0 : row;
    mask_in = '0;
    if (draining) begin
      raddr        = drain_cnt[AW-1:0];
      use_store_in = drain_cnt < w_used;
      emit_in      = 1'b1;
      last_in      = drain_cnt == w_used;
      if (drain_cnt == '0) begin
        // centre is the last pixel of the next-to-last row
        mask_in.top_ok   = h_used != HW'(2);
        mask_in.bot_ok   = 1'b1;
        mask_in.left_ok  = 1'b1;
        mask_in.right_ok = 1'b0;
      end else begin
        mask_in.top_ok   = 1'b1;
        mask_in.bot_ok   = 1'b0;
        mask_in.left_ok  = drain_cnt != CW'(1);
        mask_in.right_ok = drain_cnt != w_used;
      end
    end else begin
      raddr        = jj;
      use_store_in = 1'b1;
      emit_in      = (ii >= RW'(2)) || (ii == RW'(1) && jj != '0);
      last_in      = 1'b0;
      if (jj != '0) begin
        mask_in.top_ok   = ii != RW'(1);
        mask_in.bot_ok   = 1'b1;
        mask_in.left_ok  = jj != AW'(1);
        mask_in.right_ok = 1'b1;
      end else begin
        // centre wraps to the end of the row above
        mask_in.top_ok   = ii != RW'(2);
        mask_in.bot_ok   = 1'b1;
        mask_in.left_ok  = 1'b1;
        mask_in.right_ok = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
      col          <= '0;
      row          <= '0;
      draining     <= 1'b0;
      drain_cnt    <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_IMAGE_WIDTH:  image_width  <= cfg_data[WIDTH_REG_W-1:0];
        CFG_IMAGE_HEIGHT: image_height <= cfg_data[HEIGHT_REG_W-1:0];
        default: ;
      endcase
      col       <= '0;
      row       <= '0;
      draining  <= 1'b0;
      drain_cnt <= '0;
    end else if (accept && enters) begin
      if (draining) begin
        if (drain_cnt == w_used) begin
          draining  <= 1'b0;
          drain_cnt <= '0;
          col       <= '0;
          row       <= '0;
        end else begin
          drain_cnt <= drain_cnt + CW'(1);
        end
      end else if (CW'(jj) == w_used - CW'(1)) begin
        col <= '0;
        if (HW'(ii) == h_used - HW'(1)) begin
          row       <= '0;
          draining  <= 1'b1;
          drain_cnt <= '0;
        end else begin
          row <= ii + RW'(1);
        end
      end else begin
        col <= jj + AW'(1);
        row <= ii;
      end
    end
  end

  // line stores: upper holds row i-2, middle row i-1
  nmf3x3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
    .clk   (clk),
    .we    (s1_move && s1_is_pixel),
    .waddr (s1_addr),
    .wdata (mid_rd),
    .re    (accept && enters),
    .raddr (raddr),
    .rdata (up_rd)
  );

  nmf3x3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_middle (
    .clk   (clk),
    .we    (s1_move && s1_is_pixel),
    .waddr (s1_addr),
    .wdata (s1_pix),
    .re    (accept && enters),
    .raddr (raddr),
    .rdata (mid_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept && enters) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
    if (accept && enters) begin
      s1_is_pixel  <= !draining;
      s1_use_store <= use_store_in;
      s1_emit      <= emit_in;
      s1_last      <= last_in;
      s1_addr      <= raddr;
      s1_pix       <= din.pixel_in;
      s1_mask      <= mask_in;
    end
  end

  // window shift and masked neighbour sums
  always_comb begin
    top_v = s1_use_store ? up_rd : '0;
    mid_v = s1_use_store ? mid_rd : '0;
    bot_v = s1_is_pixel ? s1_pix : '0;
    for (int r = 0; r < 3; r++) begin
      win_next[r*3]     = win[r*3+1];
      win_next[r*3 + 1] = win[r*3+2];
    end
    win_next[2] = top_v;
    win_next[5] = mid_v;
    win_next[8] = bot_v;
    for (int c = 0; c < 9; c++) begin
      cell_ok[c] = (c != 4)
                && !(c / 3 == 0 && !s1_mask.top_ok)
                && !(c / 3 == 2 && !s1_mask.bot_ok)
                && !(c % 3 == 0 && !s1_mask.left_ok)
                && !(c % 3 == 2 && !s1_mask.right_ok);
    end
    for (int ch = 0; ch < 3; ch++) begin
      sum_next[ch] = '0;
      for (int c = 0; c < 9; c++) begin
        if (cell_ok[c]) begin
          sum_next[ch] = sum_next[ch] + SUM_W'(win_next[c][ch*CH_W +: CH_W]);
        end
      end
    end
    n_out = 3'(!s1_mask.top_ok) + 3'(!s1_mask.bot_ok)
          + 3'(!s1_mask.left_ok) + 3'(!s1_mask.right_ok);
    case (n_out)
      3'd0:    div_next = DIV_BY_8;
      3'd1:    div_next = DIV_BY_5;
      default: div_next = DIV_BY_3;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < 9; c++) begin
        win[c] <= '0;
      end
    end else if (s1_move) begin
      for (int c = 0; c < 9; c++) begin
        win[c] <= win_next[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_move && s1_emit) begin
      s2_valid <= 1'b1;
    end else if (s2_move) begin
      s2_valid <= 1'b0;
    end
    if (s1_move && s1_emit) begin
      s2_sum  <= sum_next;
      s2_div  <= div_next;
      s2_last <= s1_last;
    end
  end

  // constant division by reciprocal multiply
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      p3[ch] = 21'(s2_sum[ch]) * 21'(RECIP3);
      p5[ch] = 24'(s2_sum[ch]) * 24'(RECIP5);
      case (s2_div)
        DIV_BY_3: mean[ch] = p3[ch][18:11];
        DIV_BY_5: mean[ch] = p5[ch][20:13];
        DIV_BY_8: mean[ch] = s2_sum[ch][10:3];
        default:  mean[ch] = s2_sum[ch][10:3];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s2_move) begin
      s3_valid <= 1'b1;
    end else if (dout.ready) begin
      s3_valid <= 1'b0;
    end
    if (s2_move) begin
      // channel 0 lands in the upper lane, channel 2 in the lowest
      s3_pixel <= {ALPHA, mean[0], mean[1], mean[2]};
      s3_last  <= s2_last;
    end
  end

  assign dout.valid      = s3_valid;
  assign dout.pixel_out  = s3_pixel;
  assign dout.frame_last = s3_last;

endmodule

`default_nettype wire

// ----- rtl/nmf3x3_checker.sv -----
// port-level checks for the 3x3 neighbour mean filter, bound to the top level
// depends on: nmf3x3_pkg, neighbour_mean_filter_3x3_top_assert.svh
`timescale 1ns / 1ps
`default_nettype none

`include "neighbour_mean_filter_3x3_top_assert.svh"

module nmf3x3_checker import nmf3x3_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             out_valid,
  input logic             out_ready,
  input logic [OUT_W-1:0] pixel_out,
  input logic             frame_last
);

  // every result carries an opaque alpha byte
  `NMF_ASSERT_NOW(a_alpha_opaque, out_valid, pixel_out[OUT_W-1 -: CH_W] == ALPHA)

  // a stalled result beat holds
  `NMF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(pixel_out) && $stable(frame_last))

  // reset empties the result pipeline
  `NMF_ASSERT_NEXT_ALWAYS(a_reset_flush, rst, !out_valid)

endmodule

bind neighbour_mean_filter_3x3_top nmf3x3_checker u_nmf3x3_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (dout.valid),
  .out_ready  (dout.ready),
  .pixel_out  (dout.pixel_out),
  .frame_last (dout.frame_last)
);

`default_nettype wire
